/* design/ssir_pkg.sv */
// ----------------------------------------------------------------------------
// ssir_pkg
// Types and codes shared by the sorted set cells and the top level.
// ----------------------------------------------------------------------------
package ssir_pkg;

  // Stored entry and item value
  typedef logic signed [31:0] word_t;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_REMOVED   = 3'd3;
  localparam status_t ST_MISSING   = 3'd4;

  // Input item
  typedef struct packed {
    logic  operation;
    word_t value;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_t    status;
    word_t      removed_value;
    logic [4:0] entry_total;
    logic       is_full;
    logic       is_empty;
    word_t      largest;
  } out_item_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic  ins_en;
    logic  rem_en;
  } cell_cmd_t;

  // Compare key broadcast to every cell, with that slot's occupancy
  typedef struct packed {
    logic  occupied;
    word_t value;
  } cell_key_t;

  // Compare flags reported by a cell
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

/* design/sorted_set_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_set_insert_remove
// Ascending set of distinct signed values held in a chain of compare cells.
// ----------------------------------------------------------------------------
// Takes one item per clock. Every cell compares its entry against the value
// of the item and, in the same cycle, keeps its entry or takes that of a
// neighbour, so an insert or remove completes in the cycle it is accepted;
// the result appears in the output register on the next cycle. Input is
// stalled only while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module sorted_set_insert_remove #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ssir_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssir_pkg::out_item_t  out_item
);
  import ssir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  word_t            largest_r, largest_nxt;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic          accept, is_rem, full, found, all_lt, eq_last;
  status_t       status;
  word_t         below_last;
  cell_cmd_t     cmd [CAPACITY];
  cell_key_t     key [CAPACITY];
  cell_flag_t    flag [CAPACITY];
  word_t         entry [CAPACITY];
  logic [CAPACITY-1:0] occ_v, lt_v, eq_v, last_v, prev_v;

  // Handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_rem   = (in_item.operation == OP_REMOVE);

  // Per-slot occupancy and position markers
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ_v[i]  = (CNT_W'(i) < count_r);
      last_v[i] = ((CNT_W+1)'(i + 1) == {1'b0, count_r});
      prev_v[i] = ((CNT_W+1)'(i + 2) == {1'b0, count_r});
    end
  end

  // Compare flags gathered from the chain
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_v[i] = flag[i].lt;
      eq_v[i] = flag[i].eq;
    end
  end

  // Global decisions
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign found   = |eq_v;
  assign all_lt  = &(lt_v | ~occ_v);
  assign eq_last = |(eq_v & last_v);

  // Entry just below the last one, for a remove of the largest
  always_comb begin
    below_last = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      below_last = below_last | (entry[i] & {32{prev_v[i]}});
    end
  end

  // Outcome of the item
  always_comb begin
    if (is_rem) begin
      status = found ? ST_REMOVED : ST_MISSING;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = found ? ST_DUPLICATE : ST_INSERTED;
    end
  end

  // Compare key to the chain
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      key[i].occupied = occ_v[i];
      key[i].value    = in_item.value;
    end
  end

  // Shift command to the chain
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i].ins_en = accept && (status == ST_INSERTED);
      cmd[i].rem_en = accept && (status == ST_REMOVED);
    end
  end

  // The chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic  left_lt;
    word_t left_entry, right_entry;
    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_lt    = flag[g-1].lt;
      assign left_entry = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entry[g+1];
    end
    ssir_cell u_cell (
      .clk         (clk),
      .cmd         (cmd[g]),
      .key         (key[g]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[g]),
      .flag        (flag[g])
    );
  end

  // Count, largest entry and result
  always_comb begin
    count_nxt   = count_r;
    largest_nxt = largest_r;
    if (accept && status == ST_INSERTED) begin
      count_nxt = count_r + 1'b1;
      if (all_lt) begin
        largest_nxt = in_item.value;
      end
    end else if (accept && status == ST_REMOVED) begin
      count_nxt = count_r - 1'b1;
      if (eq_last) begin
        largest_nxt = below_last;
      end
    end
    out_nxt.status        = status;
    out_nxt.removed_value = (status == ST_REMOVED) ? in_item.value : '0;
    out_nxt.entry_total   = 5'(count_nxt);
    out_nxt.is_full       = (count_nxt == CNT_W'(CAPACITY));
    out_nxt.is_empty      = (count_nxt == '0);
    out_nxt.largest       = largest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      largest_r <= largest_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A successful insert grows the set by exactly one
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status == ST_INSERTED |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the set");

  // An empty set reports no largest entry
  a_empty_largest: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> largest_r == '0)
    else $error("largest entry held while empty");
`endif

endmodule

/* design/ssir_cell.sv */
// ----------------------------------------------------------------------------
// ssir_cell
// One slot of the sorted chain: compares its entry against the broadcast
// value and takes its left or right neighbour's entry on insert or remove.
// ----------------------------------------------------------------------------
module ssir_cell (
  input  logic                  clk,
  input  ssir_pkg::cell_cmd_t   cmd,
  input  ssir_pkg::cell_key_t   key,
  input  logic                  left_lt,
  input  ssir_pkg::word_t       left_entry,
  input  ssir_pkg::word_t       right_entry,
  output ssir_pkg::word_t       entry,
  output ssir_pkg::cell_flag_t  flag
);
  import ssir_pkg::*;

  word_t entry_r;
  word_t entry_nxt;

  // Local compare, only meaningful on an occupied slot
  assign flag.lt = key.occupied && (entry_r < key.value);
  assign flag.eq = key.occupied && (entry_r == key.value);
  assign entry   = entry_r;

  // Insert: slots at or above the sorted position move up one place.
  // Remove: slots at or above the match take the right neighbour.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en && !flag.lt) begin
      entry_nxt = left_lt ? key.value : left_entry;
    end else if (cmd.rem_en && key.occupied && !flag.lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
